>>> hdl/rmq_pkg.sv
`default_nettype none
package rmq_pkg;
    localparam int FRAC_BITS = 14;
    localparam int D_W       = 16;              // field width
    localparam int TR_W      = D_W + 2;         // sum of three elements
    localparam int ARG_W     = D_W + 1;         // root argument after clamp
    localparam int DIFF_W    = D_W + 1;         // difference or sum of two elements
    localparam int RAD_W     = 2 * D_W;         // radicand arg << FRAC_BITS
    localparam int S_W       = RAD_W / 2;       // root width
    localparam int SREM_W    = S_W + 3;         // root remainder plus two new bits
    localparam int Q_W       = D_W - 1;         // unsaturated quotient magnitude
    localparam int N_W       = DIFF_W + FRAC_BITS - 1;
    localparam int DREM_W    = S_W + 1;
    localparam int SQ_STAGES = 4;
    localparam int SQ_PER    = S_W / SQ_STAGES;
    localparam int DV_STAGES = 4;
    localparam int DV_PER    = (Q_W + DV_STAGES - 1) / DV_STAGES;
    localparam int LAT       = 1 + SQ_STAGES + 1 + DV_STAGES + 1;
    localparam int SIDE_LAT  = 1 + DV_STAGES;

    localparam logic [1:0] SLOT_X = 2'd0;
    localparam logic [1:0] SLOT_Y = 2'd1;
    localparam logic [1:0] SLOT_Z = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

    localparam logic signed [TR_W:0] ONE = (TR_W+1)'(1 << FRAC_BITS);

    typedef struct packed {
        logic signed [D_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } mat_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] d0;
        logic signed [DIFF_W-1:0] d1;
        logic signed [DIFF_W-1:0] d2;
        logic [1:0]               r;   // slot taking the half root
    } side_t;

    function automatic logic [1:0] succ(input logic [1:0] i);
        case (i)
            SLOT_X:  succ = SLOT_Y;
            SLOT_Y:  succ = SLOT_Z;
            default: succ = SLOT_X;
        endcase
    endfunction
endpackage
`default_nettype wire

>>> hdl/rmq_in_if.sv
`default_nettype none
interface rmq_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/rmq_out_if.sv
`default_nettype none
interface rmq_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] qx, qy, qz, qw;
    modport source (output valid, qx, qy, qz, qw, input ready);
    modport sink (input valid, qx, qy, qz, qw, output ready);
endinterface
`default_nettype wire

>>> hdl/rmq_front.sv
`default_nettype none
module rmq_front (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire rmq_pkg::mat_t  mat,
    output logic [rmq_pkg::ARG_W-1:0] arg,
    output rmq_pkg::side_t      side
);
    logic signed [rmq_pkg::D_W-1:0]  g [3][3];
    logic signed [rmq_pkg::TR_W-1:0] tr;
    logic signed [rmq_pkg::TR_W:0]   sarg;
    logic [1:0] i, j, k;
    logic [rmq_pkg::ARG_W-1:0] arg_next, arg_reg;
    rmq_pkg::side_t side_next, side_reg;

    always_comb
    begin
        g[0][0] = mat.m00; g[0][1] = mat.m01; g[0][2] = mat.m02;
        g[1][0] = mat.m10; g[1][1] = mat.m11; g[1][2] = mat.m12;
        g[2][0] = mat.m20; g[2][1] = mat.m21; g[2][2] = mat.m22;
        tr = rmq_pkg::TR_W'(g[0][0]) + rmq_pkg::TR_W'(g[1][1]) + rmq_pkg::TR_W'(g[2][2]);
        i = rmq_pkg::SLOT_X;
        if (g[1][1] > g[0][0])
            i = rmq_pkg::SLOT_Y;
        if (g[2][2] > g[i][i])
            i = rmq_pkg::SLOT_Z;
        j = rmq_pkg::succ(i);
        k = rmq_pkg::succ(j);
        if (tr > 0)
        begin
            sarg = (rmq_pkg::TR_W+1)'(tr) + rmq_pkg::ONE;
            side_next.r  = rmq_pkg::SLOT_W;
            side_next.d0 = rmq_pkg::DIFF_W'(g[1][2]) - rmq_pkg::DIFF_W'(g[2][1]);
            side_next.d1 = rmq_pkg::DIFF_W'(g[2][0]) - rmq_pkg::DIFF_W'(g[0][2]);
            side_next.d2 = rmq_pkg::DIFF_W'(g[0][1]) - rmq_pkg::DIFF_W'(g[1][0]);
        end
        else
        begin
            sarg = (rmq_pkg::TR_W+1)'(g[i][i]) - (rmq_pkg::TR_W+1)'(g[j][j])
                 - (rmq_pkg::TR_W+1)'(g[k][k]) + rmq_pkg::ONE;
            side_next.r  = i;
            side_next.d0 = rmq_pkg::DIFF_W'(g[j][k]) - rmq_pkg::DIFF_W'(g[k][j]);
            side_next.d1 = rmq_pkg::DIFF_W'(g[i][j]) + rmq_pkg::DIFF_W'(g[j][i]);
            side_next.d2 = rmq_pkg::DIFF_W'(g[i][k]) + rmq_pkg::DIFF_W'(g[k][i]);
        end
        // negative argument clamps to zero
        arg_next = (sarg < 0) ? '0 : sarg[rmq_pkg::ARG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_reg  <= arg_next;
            side_reg <= side_next;
        end
    end

    assign arg  = arg_reg;
    assign side = side_reg;
endmodule
`default_nettype wire

>>> hdl/rmq_sqrt.sv
`default_nettype none
module rmq_sqrt (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [rmq_pkg::ARG_W-1:0]  arg,
    input  wire rmq_pkg::side_t             side_in,
    output logic [rmq_pkg::S_W-1:0]         root,
    output rmq_pkg::side_t                  side_out
);
    localparam int NS = rmq_pkg::SQ_STAGES;

    logic [rmq_pkg::RAD_W-1:0]  v_reg    [NS];
    logic [rmq_pkg::S_W-1:0]    root_reg [NS];
    logic [rmq_pkg::SREM_W-1:0] rem_reg  [NS];
    rmq_pkg::side_t             side_reg [NS];
    logic [rmq_pkg::RAD_W-1:0]  v_next    [NS];
    logic [rmq_pkg::S_W-1:0]    root_next [NS];
    logic [rmq_pkg::SREM_W-1:0] rem_next  [NS];

    always_comb
    begin
        logic [rmq_pkg::RAD_W-1:0]  v;
        logic [rmq_pkg::S_W-1:0]    r;
        logic [rmq_pkg::SREM_W-1:0] rm;
        logic [rmq_pkg::SREM_W-1:0] trial;
        for (int st = 0; st < NS; st++)
        begin
            if (st == 0)
            begin
                v  = rmq_pkg::RAD_W'(arg) << rmq_pkg::FRAC_BITS;
                r  = '0;
                rm = '0;
            end
            else
            begin
                v  = v_reg[st-1];
                r  = root_reg[st-1];
                rm = rem_reg[st-1];
            end
            // one root bit per step, two radicand bits shifted in
            for (int n = 0; n < rmq_pkg::SQ_PER; n++)
            begin
                rm    = {rm[rmq_pkg::SREM_W-3:0], v[rmq_pkg::RAD_W-1 -: 2]};
                v     = v << 2;
                trial = {1'b0, r, 2'b01};
                if (rm >= trial)
                begin
                    rm = rm - trial;
                    r  = {r[rmq_pkg::S_W-2:0], 1'b1};
                end
                else
                    r  = {r[rmq_pkg::S_W-2:0], 1'b0};
            end
            v_next[st]    = v;
            root_next[st] = r;
            rem_next[st]  = rm;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int st = 0; st < NS; st++)
            begin
                v_reg[st]    <= v_next[st];
                root_reg[st] <= root_next[st];
                rem_reg[st]  <= rem_next[st];
                side_reg[st] <= (st == 0) ? side_in : side_reg[st-1];
            end
        end
    end

    assign root     = root_reg[NS-1];
    assign side_out = side_reg[NS-1];
endmodule
`default_nettype wire

>>> hdl/rmq_div.sv
`default_nettype none
module rmq_div (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [rmq_pkg::DIFF_W-1:0] d,
    input  wire logic [rmq_pkg::S_W-1:0]           s,
    output logic signed [rmq_pkg::D_W-1:0]         q
);
    localparam int NS = rmq_pkg::DV_STAGES;

    typedef struct packed {
        logic                        neg;
        logic                        ovf;
        logic                        zero;
        logic [rmq_pkg::S_W-1:0]     s;
        logic [rmq_pkg::Q_W-1:0]     bits;
        logic [rmq_pkg::DREM_W-1:0]  rem;
        logic [rmq_pkg::Q_W-1:0]     quo;
    } dv_t;

    dv_t prep_next, prep_reg;
    dv_t st_next [NS];
    dv_t st_reg  [NS];

    always_comb
    begin
        logic [rmq_pkg::DIFF_W-1:0] mag;
        logic [rmq_pkg::N_W-1:0]    num;
        mag = d[rmq_pkg::DIFF_W-1] ? rmq_pkg::DIFF_W'(-d) : rmq_pkg::DIFF_W'(d);
        // rounding half of the divisor folded into the dividend
        num = {mag, {(rmq_pkg::FRAC_BITS-1){1'b0}}} + rmq_pkg::N_W'(s >> 1);
        prep_next.neg  = d[rmq_pkg::DIFF_W-1];
        prep_next.zero = (s == '0);
        prep_next.ovf  = ((rmq_pkg::N_W+1)'(num) >=
                          {s, {rmq_pkg::Q_W{1'b0}}});
        prep_next.s    = s;
        prep_next.bits = num[rmq_pkg::Q_W-1:0];
        prep_next.rem  = rmq_pkg::DREM_W'(num[rmq_pkg::N_W-1:rmq_pkg::Q_W]);
        prep_next.quo  = '0;
    end

    always_comb
    begin
        dv_t w;
        for (int st = 0; st < NS; st++)
        begin
            w = (st == 0) ? prep_reg : st_reg[st-1];
            for (int n = 0; n < rmq_pkg::DV_PER; n++)
            begin
                if (st * rmq_pkg::DV_PER + n < rmq_pkg::Q_W)
                begin
                    w.rem  = {w.rem[rmq_pkg::DREM_W-2:0], w.bits[rmq_pkg::Q_W-1]};
                    w.bits = w.bits << 1;
                    if (w.rem >= rmq_pkg::DREM_W'(w.s))
                    begin
                        w.rem = w.rem - rmq_pkg::DREM_W'(w.s);
                        w.quo = {w.quo[rmq_pkg::Q_W-2:0], 1'b1};
                    end
                    else
                        w.quo = {w.quo[rmq_pkg::Q_W-2:0], 1'b0};
                end
            end
            st_next[st] = w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg <= prep_next;
            for (int st = 0; st < NS; st++)
                st_reg[st] <= st_next[st];
        end
    end

    always_comb
    begin
        if (st_reg[NS-1].zero)
            q = '0;
        else if (st_reg[NS-1].ovf)
            q = st_reg[NS-1].neg ? {1'b1, {(rmq_pkg::D_W-1){1'b0}}}
                                 : {1'b0, {(rmq_pkg::D_W-1){1'b1}}};
        else if (st_reg[NS-1].neg)
            q = -$signed({1'b0, st_reg[NS-1].quo});
        else
            q = $signed({1'b0, st_reg[NS-1].quo});
    end
endmodule
`default_nettype wire

>>> hdl/rotation_matrix_to_quaternion_core.sv
`default_nettype none
// rotation matrix to quaternion, Q2.14 in and out
// in_ch carries one request per matrix: m00..m22, row-major, signed
// out_ch returns qx, qy, qz, qw, saturated to the 16-bit range
// a request is taken at a rising edge with valid and ready both high
// an accepted request reaches the output through one stage
// for trace and branch selection, four for the square root (four root bits
// each), one for divider setup, four for the three parallel dividers (four
// quotient bits per stage, three in the last) and one output register
// throughput is one matrix per cycle while the receiver does not stall; every stage is a register slice
// reset clears the stage valid bits only, no result is pending after it
// when the receiver holds ready low with a result waiting, the whole
// pipeline freezes and in_ch.ready drops; nothing is lost or repeated
module rotation_matrix_to_quaternion_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rmq_in_if.sink     in_ch,
    rmq_out_if.source  out_ch
);
    logic en;
    logic [rmq_pkg::LAT-1:0] vld_reg, vld_next;
    rmq_pkg::mat_t mat;
    logic [rmq_pkg::ARG_W-1:0] arg;
    rmq_pkg::side_t side_f, side_s;
    logic [rmq_pkg::S_W-1:0] root;
    logic [rmq_pkg::S_W-1:0] hroot;
    logic [1:0]              r_reg  [rmq_pkg::SIDE_LAT];
    logic [rmq_pkg::S_W-1:0] hr_reg [rmq_pkg::SIDE_LAT];
    logic signed [rmq_pkg::D_W-1:0] dq0, dq1, dq2;
    logic signed [rmq_pkg::D_W-1:0] q_next [4];
    logic signed [rmq_pkg::D_W-1:0] q_reg  [4];

    assign en = !vld_reg[rmq_pkg::LAT-1] || out_ch.ready;
    assign in_ch.ready = en;

    assign mat = '{m00: in_ch.m00, m01: in_ch.m01, m02: in_ch.m02,
                   m10: in_ch.m10, m11: in_ch.m11, m12: in_ch.m12,
                   m20: in_ch.m20, m21: in_ch.m21, m22: in_ch.m22};

    rmq_front u_front (.clk(clk), .en(en), .mat(mat), .arg(arg), .side(side_f));

    rmq_sqrt u_sqrt (.clk(clk), .en(en), .arg(arg), .side_in(side_f),
                     .root(root), .side_out(side_s));

    rmq_div u_div0 (.clk(clk), .en(en), .d(side_s.d0), .s(root), .q(dq0));
    rmq_div u_div1 (.clk(clk), .en(en), .d(side_s.d1), .s(root), .q(dq1));
    rmq_div u_div2 (.clk(clk), .en(en), .d(side_s.d2), .s(root), .q(dq2));

    // half root rounds half up
    assign hroot = rmq_pkg::S_W'(({1'b0, root} + 1'b1) >> 1);

    assign vld_next = {vld_reg[rmq_pkg::LAT-2:0], in_ch.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int n = 0; n < rmq_pkg::SIDE_LAT; n++)
            begin
                r_reg[n]  <= (n == 0) ? side_s.r : r_reg[n-1];
                hr_reg[n] <= (n == 0) ? hroot    : hr_reg[n-1];
            end
            for (int t = 0; t < 4; t++)
                q_reg[t] <= q_next[t];
        end
    end

    // steer half root and quotients to their slots
    always_comb
    begin
        logic [1:0] rs;
        logic signed [rmq_pkg::D_W-1:0] hv;
        rs = r_reg[rmq_pkg::SIDE_LAT-1];
        hv = $signed(hr_reg[rmq_pkg::SIDE_LAT-1]);
        if (rs == rmq_pkg::SLOT_W)
        begin
            q_next[0] = dq0;
            q_next[1] = dq1;
            q_next[2] = dq2;
            q_next[3] = hv;
        end
        else
        begin
            q_next[3] = dq0;
            for (int t = 0; t < 3; t++)
            begin
                if (2'(t) == rs)
                    q_next[t] = hv;
                else if (2'(t) == rmq_pkg::succ(rs))
                    q_next[t] = dq1;
                else
                    q_next[t] = dq2;
            end
        end
    end

    assign out_ch.valid = vld_reg[rmq_pkg::LAT-1];
    assign out_ch.qx = q_reg[0];
    assign out_ch.qy = q_reg[1];
    assign out_ch.qz = q_reg[2];
    assign out_ch.qw = q_reg[3];

`ifndef NO_ASSERTIONS
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> vld_reg[0])
        else $error("accepted request did not enter the pipeline");
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
        else $error("ready low without a blocked result");
`endif
endmodule
`default_nettype wire

>>> sim/rmq_scoreboard.sv
`timescale 1ns / 1ps
// expected quaternions for accepted matrices, checked in order
class quat_scoreboard;
    typedef struct {
        logic signed [15:0] qx, qy, qz, qw;
    } quat_t;

    quat_t pending[$];
    int    errors;

    function new();
        errors = 0;
    endfunction

    static function longint clamp_root(longint a);
        longint r, v, b;
        if (a <= 0)
            return 0;
        v = a << rmq_pkg::FRAC_BITS;
        r = 0;
        b = longint'(1) << 60;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // d / (2 s) rounded, ties away from zero
    static function longint div_round(longint d, longint s);
        longint n, mag, q;
        if (s <= 0)
            return 0;
        n = d * (longint'(1) << (rmq_pkg::FRAC_BITS - 1));
        mag = (n < 0) ? -n : n;
        q = (mag + (s >> 1)) / s;
        return (n < 0) ? -q : q;
    endfunction

    static function logic signed [15:0] sat(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function void note_matrix(rmq_pkg::mat_t m);
        longint g[3][3];
        longint q[4];
        longint tr, s;
        int     i, j, k;
        quat_t  e;
        g[0][0] = m.m00; g[0][1] = m.m01; g[0][2] = m.m02;
        g[1][0] = m.m10; g[1][1] = m.m11; g[1][2] = m.m12;
        g[2][0] = m.m20; g[2][1] = m.m21; g[2][2] = m.m22;
        tr = g[0][0] + g[1][1] + g[2][2];
        if (tr > 0)
        begin
            s = clamp_root(tr + (1 << rmq_pkg::FRAC_BITS));
            q[3] = (s + 1) >> 1;
            q[0] = div_round(g[1][2] - g[2][1], s);
            q[1] = div_round(g[2][0] - g[0][2], s);
            q[2] = div_round(g[0][1] - g[1][0], s);
        end
        else
        begin
            i = 0;
            if (g[1][1] > g[0][0])
                i = 1;
            if (g[2][2] > g[i][i])
                i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            s = clamp_root(g[i][i] - (g[j][j] + g[k][k]) + (1 << rmq_pkg::FRAC_BITS));
            q[i] = (s + 1) >> 1;
            q[3] = div_round(g[j][k] - g[k][j], s);
            q[j] = div_round(g[i][j] + g[j][i], s);
            q[k] = div_round(g[i][k] + g[k][i], s);
        end
        e.qx = sat(q[0]);
        e.qy = sat(q[1]);
        e.qz = sat(q[2]);
        e.qw = sat(q[3]);
        pending.push_back(e);
    endfunction

    task report(string what, logic signed [15:0] got, logic signed [15:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_quat(logic signed [15:0] qx, qy, qz, qw);
        quat_t e;
        if (pending.size() == 0)
        begin
            $display("mismatch: result with no request outstanding");
            errors++;
        end
        else
        begin
            e = pending.pop_front();
            if (qx !== e.qx) report("qx", qx, e.qx);
            if (qy !== e.qy) report("qy", qy, e.qy);
            if (qz !== e.qz) report("qz", qz, e.qz);
            if (qw !== e.qw) report("qw", qw, e.qw);
        end
    endtask
endclass

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    localparam int RANDOM_ITEMS = 1880;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    longint cycles;
    bit     sending_done;
    bit     hold_steady;

    rmq_in_if  in_ch();
    rmq_out_if out_ch();

    rotation_matrix_to_quaternion_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    quat_scoreboard quat_sb = new();

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11,
         in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22} = '0;
        out_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end
    initial cycles = 0;

    function automatic logic signed [15:0] rnd_elem();
        case ($urandom_range(0, 5))
            0: return 16'sh4000;
            1: return 16'shc000;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            3: return 16'(int'($urandom_range(0, 800)) - 400);
            default: return 16'($urandom);
        endcase
    endfunction

    // signed permutation of axes with noise, or one time in four random elements
    function automatic rmq_pkg::mat_t rnd_matrix();
        logic signed [15:0] g[3][3];
        rmq_pkg::mat_t m;
        int   p, sgn;
        if ($urandom_range(0, 3) == 0)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    g[r][c] = rnd_elem();
        end
        else
        begin
            p = $urandom_range(0, 2);
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    sgn = $urandom_range(0, 1) ? 1 : -1;
                    if (c == (r + p) % 3)
                        g[r][c] = 16'(sgn * int'($urandom_range(9000, 16384)));
                    else
                        g[r][c] = 16'(sgn * int'($urandom_range(0, 9000)));
                end
        end
        m.m00 = g[0][0]; m.m01 = g[0][1]; m.m02 = g[0][2];
        m.m10 = g[1][0]; m.m11 = g[1][1]; m.m12 = g[1][2];
        m.m20 = g[2][0]; m.m21 = g[2][1]; m.m22 = g[2][2];
        return m;
    endfunction

    task automatic send_matrix(rmq_pkg::mat_t m);
        int gap;
        gap = hold_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.m00 <= m.m00; in_ch.m01 <= m.m01; in_ch.m02 <= m.m02;
        in_ch.m10 <= m.m10; in_ch.m11 <= m.m11; in_ch.m12 <= m.m12;
        in_ch.m20 <= m.m20; in_ch.m21 <= m.m21; in_ch.m22 <= m.m22;
        do @(posedge clk); while (!in_ch.ready);
        quat_sb.note_matrix(m);
    endtask

    function automatic rmq_pkg::mat_t diag(int a, int b, int c, int off);
        rmq_pkg::mat_t m;
        m = '{default: 16'(off)};
        m.m00 = 16'(a); m.m11 = 16'(b); m.m22 = 16'(c);
        return m;
    endfunction

    initial
    begin
        rmq_pkg::mat_t m;
        sending_done = 0;
        hold_steady = 0;
        @(posedge rst_n);
        @(posedge clk);
        // identity and half turns about each axis
        send_matrix(diag(16384, 16384, 16384, 0));
        send_matrix(diag(16384, -16384, -16384, 0));
        send_matrix(diag(-16384, 16384, -16384, 0));
        send_matrix(diag(-16384, -16384, 16384, 0));
        // ties on the diagonal, zero or negative trace
        send_matrix(diag(0, 0, 0, 0));
        send_matrix(diag(-100, -100, -100, 50));
        send_matrix(diag(-16384, -16384, -16384, 123));
        // mixed-sign diagonals; the root argument stays positive
        send_matrix(diag(-32768, -32768, 32767, -32768));
        send_matrix(diag(-32768, 32767, 32767, 32767));
        send_matrix(diag(-20000, 1000, 1000, 7));
        // extremes: full-scale and unit-sized elements
        send_matrix(diag(1, 0, 0, 32767));
        send_matrix(diag(1, 0, 0, -32768));
        send_matrix(diag(32767, 32767, 32767, -32768));
        send_matrix(diag(-32768, -32768, -32768, 32767));
        m = diag(-32768, -32768, -32768, 0);
        m.m01 = 16'sh7fff; m.m10 = 16'sh8000;
        send_matrix(m);
        m = diag(5, -32768, -32768, 0);
        m.m12 = 16'sh7fff; m.m21 = 16'sh8000;
        send_matrix(m);
        send_matrix(diag(0, 1, 0, -1));
        send_matrix(diag(0, 0, 1, 1));
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 200 == 0)
                hold_steady = (n % 400 == 0);
            send_matrix(rnd_matrix());
        end
        in_ch.valid <= 1'b0;
        sending_done = 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            quat_sb.check_quat(out_ch.qx, out_ch.qy, out_ch.qz, out_ch.qw);
    end

    // receiver stall pattern
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = hold_steady ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    initial
    begin
        wait (sending_done);
        while (quat_sb.pending.size() != 0)
            @(posedge clk);
        repeat (rmq_pkg::LAT + 20) @(posedge clk);
        if (quat_sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
